// ----- sv/selective_repeat_sender_window_core_defines.svh -----
// ----------------------------------------------------------------------------
// Selective-repeat sender window: assertion macros
// Clocked assertion wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_CORE_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRSW_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SRSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SRSW_ASSERT_ALWAYS(label, expr, msg)
`define SRSW_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- sv/srsw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat sender window package
// Widths, codes and types shared by the window cells and the core.
// ----------------------------------------------------------------------------
package srsw_pkg;
  localparam int SLOTS = 31;
  localparam int POS_W = 5;
  localparam int LEN_W = 10;
  localparam int AGE_W = 32;
  localparam int SEQ_W = 8;
  localparam int WIN_W = 5;
  localparam int ACT_W = 3;
  localparam int OP_W  = 2;

  localparam logic [LEN_W-1:0] MAX_PAYLOAD   = 10'd512;
  localparam logic [AGE_W-1:0] TIMEOUT_RESET = 32'd5000;
  localparam logic [WIN_W-1:0] LIMIT_RESET   = 5'd31;
  localparam logic [POS_W-1:0] LAST_POS      = 5'(SLOTS - 1);

  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_NACK = 2'd2;
  localparam logic [OP_W-1:0] OP_TICK = 2'd3;

  localparam logic [ACT_W-1:0] ACT_NONE    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEND    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_RETX    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REFUSED = 3'd3;
  localparam logic [ACT_W-1:0] ACT_IGNORED = 3'd4;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [AGE_W-1:0] age_t;

  typedef struct packed {
    logic             shift;
    logic             load;
    logic [POS_W-1:0] load_pos;
  } chain_ctrl_t;
endpackage

// ----- sv/srsw_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window cell
// Holds one outstanding entry; loads a new packet or takes its neighbour's.
// ----------------------------------------------------------------------------
module srsw_cell (
  input  logic          clk,
  input  logic          shift,
  input  logic          load,
  input  srsw_pkg::len_t load_len,
  input  srsw_pkg::len_t nbr_len,
  input  srsw_pkg::age_t nbr_age,
  output srsw_pkg::len_t len,
  output srsw_pkg::age_t age
);
  always_ff @(posedge clk) begin
    if (load) begin
      len <= load_len;
      age <= '0;
    end else if (shift) begin
      len <= nbr_len;
      age <= nbr_age;
    end
  end
endmodule

// ----- sv/srsw_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window chain
// Ring of cells ordered from the oldest entry; rotates towards the head.
// ----------------------------------------------------------------------------
module srsw_chain (
  input  logic                 clk,
  input  srsw_pkg::chain_ctrl_t ctrl,
  input  srsw_pkg::len_t        load_len,
  input  srsw_pkg::len_t        tail_len,
  input  srsw_pkg::age_t        tail_age,
  output srsw_pkg::len_t        head_len,
  output srsw_pkg::age_t        head_age
);
  srsw_pkg::len_t len_q [srsw_pkg::SLOTS];
  srsw_pkg::age_t age_q [srsw_pkg::SLOTS];

  for (genvar i = 0; i < srsw_pkg::SLOTS; i++) begin : g_cell
    srsw_pkg::len_t nbr_len;
    srsw_pkg::age_t nbr_age;
    if (i == srsw_pkg::SLOTS - 1) begin : g_tail
      assign nbr_len = tail_len;
      assign nbr_age = tail_age;
    end else begin : g_mid
      assign nbr_len = len_q[i+1];
      assign nbr_age = age_q[i+1];
    end
    srsw_cell u_cell (
      .clk      (clk),
      .shift    (ctrl.shift),
      .load     (ctrl.load && (ctrl.load_pos == srsw_pkg::POS_W'(i))),
      .load_len (load_len),
      .nbr_len  (nbr_len),
      .nbr_age  (nbr_age),
      .len      (len_q[i]),
      .age      (age_q[i])
    );
  end

  assign head_len = len_q[0];
  assign head_age = age_q[0];
endmodule

// ----- sv/selective_repeat_sender_window_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat sender window core
// Tracks outstanding packets, sequence numbers and timeouts for the sender.
// ----------------------------------------------------------------------------
// channel   direction  signals
// in        sink       in_valid/in_ready: operation seqnum window payload_length
// out       source     out_valid/out_ready: action out_seqnum slot out_length
//                      can_send outstanding last
// cfg       sink       cfg_wr_en/cfg_wr_data: timeout_ticks
//
// Send, out-of-window ack/nack, ack freeing nothing and tick with nothing
// outstanding: no rotation. Ack freeing k entries: k rotation steps, then
// finish. Nack and tick: one full rotation of the 31-cell ring, then finish.
// Reset clears the counters and resets limit and timeout; cells are undefined.
// A stalled output word holds the rotation where it stands.
// ----------------------------------------------------------------------------
`include "selective_repeat_sender_window_core_defines.svh"

module selective_repeat_sender_window_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  seqnum,
  input  logic [4:0]  window,
  input  logic [9:0]  payload_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  action,
  output logic [7:0]  out_seqnum,
  output logic [4:0]  slot,
  output logic [9:0]  out_length,
  output logic        can_send,
  output logic [4:0]  outstanding,
  output logic        last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam int PW = srsw_pkg::POS_W;
  localparam int SW = srsw_pkg::SEQ_W;

  // architectural state
  logic [1:0]                 st;
  logic [SW-1:0]              next_seq;
  logic [PW-1:0]              oldest_slot;
  logic [PW-1:0]              count;
  logic [srsw_pkg::WIN_W-1:0] limit;
  srsw_pkg::age_t             timeout;

  // rotation context
  logic [srsw_pkg::OP_W-1:0]  r_op;
  logic [PW-1:0]              r_len;    // rotations to run
  logic [PW-1:0]              r_hit;    // nack position
  logic [SW-1:0]              r_seq;
  logic [srsw_pkg::WIN_W-1:0] r_win;
  logic [PW-1:0]              step;
  logic [PW-1:0]              scan_slot;
  logic [SW-1:0]              scan_seq;

  // held retransmission, released once the next one (or the end) is known
  logic                 hvalid;
  logic [SW-1:0]        h_seq;
  logic [PW-1:0]        h_slot;
  srsw_pkg::len_t       h_len;

  srsw_pkg::chain_ctrl_t ctrl;
  srsw_pkg::len_t        head_len, tail_len, load_len;
  srsw_pkg::age_t        head_age, tail_age, age_inc;

  logic                  adv, accept, rot_go, rot_end;
  logic [SW-1:0]         oldest_seq, offset;
  logic [PW:0]           slot_sum;
  logic [PW-1:0]         send_slot, scan_slot_inc;
  logic                  room, in_range, expired, retx;
  logic [PW-1:0]         count_next;
  logic [srsw_pkg::WIN_W-1:0] limit_next;

  // emitted word
  logic                        emit, e_last;
  logic [srsw_pkg::ACT_W-1:0]  e_act;
  logic [SW-1:0]               e_seq;
  logic [PW-1:0]               e_slot;
  srsw_pkg::len_t              e_len;

  assign adv      = !out_valid || out_ready;
  assign in_ready = (st == ST_IDLE) && adv;
  assign accept   = in_valid && in_ready;
  assign rot_go   = (st == ST_ROT) && adv;
  assign rot_end  = rot_go && (step == r_len - PW'(1));

  assign oldest_seq = next_seq - SW'(count);
  assign offset     = seqnum - oldest_seq;
  assign room       = (count < limit) && (count < srsw_pkg::LAST_POS + PW'(1));

  assign slot_sum  = {1'b0, oldest_slot} + {1'b0, count};
  assign send_slot = (slot_sum >= (PW+1)'(srsw_pkg::SLOTS))
                     ? PW'(slot_sum - (PW+1)'(srsw_pkg::SLOTS)) : slot_sum[PW-1:0];
  assign scan_slot_inc = (scan_slot == srsw_pkg::LAST_POS) ? '0 : scan_slot + PW'(1);

  assign load_len = (payload_length > srsw_pkg::MAX_PAYLOAD)
                    ? srsw_pkg::MAX_PAYLOAD : payload_length;

  // head processing on each rotation step
  assign age_inc  = (head_age != '1) ? head_age + srsw_pkg::AGE_W'(1) : head_age;
  assign in_range = step < count;
  assign expired  = age_inc > timeout;
  assign retx     = rot_go && (r_op == srsw_pkg::OP_TICK) && in_range && expired;

  always_comb begin
    tail_len = head_len;
    tail_age = head_age;
    if (r_op == srsw_pkg::OP_TICK && in_range) begin
      tail_age = expired ? '0 : age_inc;
    end else if (r_op == srsw_pkg::OP_NACK && step == r_hit) begin
      tail_age = '0;
    end
  end

  assign ctrl.shift    = rot_go;
  assign ctrl.load     = accept && (operation == srsw_pkg::OP_SEND) && room;
  assign ctrl.load_pos = count;

  srsw_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_len (load_len),
    .tail_len (tail_len),
    .tail_age (tail_age),
    .head_len (head_len),
    .head_age (head_age)
  );

  // next counters, used both for the state and for the status in the word
  always_comb begin
    count_next = count;
    limit_next = limit;
    if (ctrl.load) begin
      count_next = count + PW'(1);
    end
    if (accept && operation == srsw_pkg::OP_ACK && offset == '0) begin
      limit_next = window;
    end
    if (rot_end && r_op == srsw_pkg::OP_ACK) begin
      count_next = count - r_len;
      limit_next = r_win;
    end
    if (rot_end && r_op == srsw_pkg::OP_NACK) begin
      limit_next = r_win;
    end
  end

  // word selection
  always_comb begin
    emit   = 1'b0;
    e_last = 1'b1;
    e_act  = srsw_pkg::ACT_NONE;
    e_seq  = '0;
    e_slot = '0;
    e_len  = '0;
    if (accept) begin
      unique case (operation)
        srsw_pkg::OP_SEND: begin
          emit = 1'b1;
          if (room) begin
            e_act  = srsw_pkg::ACT_SEND;
            e_seq  = next_seq;
            e_slot = send_slot;
            e_len  = load_len;
          end else begin
            e_act = srsw_pkg::ACT_REFUSED;
          end
        end
        srsw_pkg::OP_ACK: begin
          if (offset > SW'(count)) begin
            emit  = 1'b1;
            e_act = srsw_pkg::ACT_IGNORED;
          end else if (offset == '0) begin
            emit = 1'b1;
          end
        end
        srsw_pkg::OP_NACK: begin
          if (offset >= SW'(count)) begin
            emit  = 1'b1;
            e_act = srsw_pkg::ACT_IGNORED;
          end
        end
        srsw_pkg::OP_TICK: begin
          emit = (count == '0);
        end
        default: emit = 1'b0;
      endcase
    end else if (retx && hvalid) begin
      emit   = 1'b1;
      e_last = 1'b0;
      e_act  = srsw_pkg::ACT_RETX;
      e_seq  = h_seq;
      e_slot = h_slot;
      e_len  = h_len;
    end else if (st == ST_FIN && adv) begin
      emit = 1'b1;
      if (hvalid) begin
        e_act  = srsw_pkg::ACT_RETX;
        e_seq  = h_seq;
        e_slot = h_slot;
        e_len  = h_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_IDLE;
      next_seq    <= '0;
      oldest_slot <= '0;
      count       <= '0;
      limit       <= srsw_pkg::LIMIT_RESET;
      timeout     <= srsw_pkg::TIMEOUT_RESET;
      out_valid   <= 1'b0;
      hvalid      <= 1'b0;
    end else begin
      count <= count_next;
      limit <= limit_next;
      if (cfg_wr_en) begin
        timeout <= cfg_wr_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.load) begin
        next_seq <= next_seq + SW'(1);
      end
      unique case (st)
        ST_IDLE: begin
          if (accept && !emit) begin
            // start a rotation from the oldest entry
            st     <= ST_ROT;
            hvalid <= 1'b0;
            r_len  <= (operation == srsw_pkg::OP_ACK) ? offset[PW-1:0]
                                                      : srsw_pkg::LAST_POS + PW'(1);
          end
        end
        ST_ROT: begin
          if (rot_end) begin
            st <= ST_FIN;
            if (r_op == srsw_pkg::OP_ACK) begin
              oldest_slot <= scan_slot_inc;
            end
          end
          if (retx) begin
            hvalid <= 1'b1;
          end else if (rot_go && r_op == srsw_pkg::OP_NACK && step == r_hit) begin
            hvalid <= 1'b1;
          end
        end
        ST_FIN: begin
          if (adv) begin
            st     <= ST_IDLE;
            hvalid <= 1'b0;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (emit) begin
      action      <= e_act;
      out_seqnum  <= e_seq;
      slot        <= e_slot;
      out_length  <= e_len;
      last        <= e_last;
      outstanding <= count_next;
      can_send    <= (count_next < limit_next) && (count_next < srsw_pkg::LAST_POS + PW'(1));
    end
    if (accept) begin
      r_op      <= operation;
      r_hit     <= offset[PW-1:0];
      r_seq     <= seqnum;
      r_win     <= window;
      step      <= '0;
      scan_slot <= oldest_slot;
      scan_seq  <= oldest_seq;
    end else if (rot_go) begin
      step      <= step + PW'(1);
      scan_slot <= scan_slot_inc;
      scan_seq  <= scan_seq + SW'(1);
    end
    if (retx) begin
      h_seq  <= scan_seq;
      h_slot <= scan_slot;
      h_len  <= head_len;
    end else if (rot_go && r_op == srsw_pkg::OP_NACK && step == r_hit) begin
      h_seq  <= r_seq;
      h_slot <= scan_slot;
      h_len  <= head_len;
    end
  end

  `SRSW_ASSERT_ALWAYS(a_count_bound, count <= srsw_pkg::LAST_POS + PW'(1), "count beyond ring")
  `SRSW_ASSERT_NEXT(a_ready_idle, in_ready, $past(st) == ST_IDLE, "ready outside idle")
  `SRSW_ASSERT_NEXT(a_fin_last, st == ST_FIN && adv, st == ST_IDLE && out_valid && last, "finish without last word")
endmodule
